/* hw/rtl/fenwick_range_add_point_query_mod_assert.svh */
// Assertion macros for the Fenwick range-add / point-query block
`ifndef FENWICK_RANGE_ADD_POINT_QUERY_MOD_ASSERT_SVH
`define FENWICK_RANGE_ADD_POINT_QUERY_MOD_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FRAPQ_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
// next-cycle implication
`define FRAPQ_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`else
`define FRAPQ_ASSERT_NOW(label, clk, rst, cond, expr, msg)
`define FRAPQ_ASSERT_NEXT(label, clk, rst, cond, expr, msg)
`endif
`endif

/* hw/rtl/frapq_pkg.sv */
// Shared widths, types and the modulus for the Fenwick range-add block
`default_nettype none
package frapq_pkg;
   localparam int POS_W  = 18;
   localparam int VAL_W  = 30;
   localparam int TREE_W = 2;

   typedef logic [VAL_W-1:0]  val_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [TREE_W-1:0] tree_type;

   localparam val_type PRIME = 30'd1000000007;
endpackage
`default_nettype wire

/* hw/rtl/frapq_intf.sv */
// Valid/ready channel interfaces: request, response and CSR write
`default_nettype none
interface frapq_req_if import frapq_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     op;
   tree_type which_tree;
   pos_type  range_start;
   pos_type  range_end;
   val_type  amount;
   pos_type  position;

   modport source (output valid, op, which_tree, range_start, range_end, amount, position,
                   input ready);
   modport sink   (input valid, op, which_tree, range_start, range_end, amount, position,
                   output ready);
endinterface

interface frapq_rsp_if import frapq_pkg::*; ();
   logic    valid;
   logic    ready;
   val_type point_value;

   modport source (output valid, point_value, input ready);
   modport sink   (input valid, point_value, output ready);
endinterface

interface frapq_csr_if import frapq_pkg::*; ();
   logic    valid;
   logic    ready;
   pos_type used_size;

   modport source (output valid, used_size, input ready);
   modport sink   (input valid, used_size, output ready);
endinterface
`default_nettype wire

/* hw/rtl/frapq_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port
`default_nettype none
module frapq_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1024
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* hw/rtl/frapq_modadd.sv */
// Modular adder: (a + b) mod PRIME for operands already below PRIME
`default_nettype none
module frapq_modadd import frapq_pkg::*; (
   input  val_type a_val,
   input  val_type b_val,
   output val_type sum_val
);
   logic [VAL_W:0] raw_sum;

   assign raw_sum = {1'b0, a_val} + {1'b0, b_val};
   assign sum_val = (raw_sum >= {1'b0, PRIME}) ? VAL_W'(raw_sum - {1'b0, PRIME})
                                               : raw_sum[VAL_W-1:0];
endmodule
`default_nettype wire

/* hw/rtl/fenwick_range_add_point_query_mod.sv */
// Top level: Fenwick range-add / point-query engine over a shared tree RAM
//
// Keeps TREE_COUNT binary indexed trees of residues mod 1000000007 in one RAM
// (TREE_COUNT * (MAX_POSITIONS + 1) words of 30 bits). A request beat with op 0
// adds amount over range_start..range_end of which_tree (add at start, subtract
// at end + 1, each walk stopping past the used size) and returns nothing; op 1
// returns one response beat with the value at position. After reset the block
// runs a clearing pass that zeroes every RAM word, with req_bus.ready low; CSR
// writes are taken at any time. Timing: one tree entry per cycle, limited by
// the single RAM read port and the one modular adder that serves both walks.
// A query reads one entry per set bit of the clamped position (at most 17),
// drains the last read, loads the response register once any earlier response
// has been taken, and returns to idle. A range add runs two upward walks, each
// touching at most log2(size) + 1 entries. The block takes the next request
// beat while a response still waits in its register.
`default_nettype none
module fenwick_range_add_point_query_mod import frapq_pkg::*; #(
   parameter int MAX_POSITIONS = 131072,
   parameter int TREE_COUNT    = 3
) (
   input  wire          clock,
   input  wire          reset,
   frapq_req_if.sink    req_bus,
   frapq_rsp_if.source  rsp_bus,
   frapq_csr_if.sink    csr_bus
);
   `include "fenwick_range_add_point_query_mod_assert.svh"

   // index widths: IW holds MAX_POSITIONS, WW also holds end + 1 and walk overshoot
   localparam int IW    = $clog2(MAX_POSITIONS + 1);
   localparam int WW    = ((IW > POS_W) ? IW : POS_W) + 1;
   localparam int DEPTH = TREE_COUNT * (MAX_POSITIONS + 1);
   localparam int AW    = $clog2(DEPTH);

   typedef logic [WW-1:0] idx_type;
   typedef logic [AW-1:0] addr_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_PUT
   } state_type;

   state_type state_ff, state_in;
   addr_type  clr_addr_ff, clr_addr_in;
   pos_type   used_size_ff, used_size_in;
   idx_type   size_ff, size_in;
   idx_type   idx_ff, idx_in;
   idx_type   end_ff, end_in;
   logic      is_query_ff, is_query_in;
   logic      second_ff, second_in;
   val_type   delta_ff, delta_in;
   val_type   sum_ff, sum_in;
   addr_type  base_ff, base_in;
   logic      rd_valid_ff, rd_valid_in;
   addr_type  wr_addr_ff, wr_addr_in;
   logic      rsp_valid_ff, rsp_valid_in;
   val_type   point_value_ff, point_value_in;

   // RAM ports
   logic     ram_wr_en;
   addr_type ram_wr_addr;
   val_type  ram_wr_data;
   logic     ram_rd_en;
   addr_type ram_rd_addr;
   val_type  ram_rd_data;

   // shared modular adder
   val_type  add_b;
   val_type  add_sum;

   // walk helpers
   idx_type  idx_up;
   idx_type  idx_dn;
   logic     idx_ok;
   val_type  delta_neg;

   // request decode
   logic     tree_ok;
   val_type  amt_red;
   idx_type  eff_size;
   idx_type  req_pos;
   idx_type  req_start;

   frapq_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // one adder: tree entry + delta on updates, running sum + entry on queries
   assign add_b = is_query_ff ? sum_ff : delta_ff;

   frapq_modadd u_modadd (
      .a_val   (ram_rd_data),
      .b_val   (add_b),
      .sum_val (add_sum)
   );

   // lowest set bit step: up for updates, strip it for queries
   assign idx_up    = idx_ff + (idx_ff & (~idx_ff + idx_type'(1)));
   assign idx_dn    = idx_ff & (idx_ff - idx_type'(1));
   assign idx_ok    = (idx_ff != '0) && (idx_ff <= size_ff);
   assign delta_neg = (delta_ff == '0) ? '0 : PRIME - delta_ff;

   assign tree_ok   = (32'(req_bus.which_tree) < TREE_COUNT);
   // amount < 2^30 < 2 * PRIME, so one subtract reduces it
   assign amt_red   = (req_bus.amount >= PRIME) ? req_bus.amount - PRIME : req_bus.amount;
   assign eff_size  = (idx_type'(used_size_ff) > idx_type'(MAX_POSITIONS))
                    ? idx_type'(MAX_POSITIONS) : idx_type'(used_size_ff);
   assign req_pos   = (idx_type'(req_bus.position) > eff_size)
                    ? eff_size : idx_type'(req_bus.position);
   assign req_start = (req_bus.range_start == '0) ? idx_type'(1)
                                                  : idx_type'(req_bus.range_start);

   // read issue: one entry per walk cycle
   assign ram_rd_en   = (state_ff == S_WALK) && idx_ok;
   assign ram_rd_addr = base_ff + AW'(idx_ff);

   // write back: clearing pass, or read-modify-write of an update walk
   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = rd_valid_ff && !is_query_ff;
         ram_wr_addr = wr_addr_ff;
         ram_wr_data = add_sum;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      used_size_in   = used_size_ff;
      size_in        = size_ff;
      idx_in         = idx_ff;
      end_in         = end_ff;
      is_query_in    = is_query_ff;
      second_in      = second_ff;
      delta_in       = delta_ff;
      sum_in         = sum_ff;
      base_in        = base_ff;
      rd_valid_in    = ram_rd_en;
      wr_addr_in     = ram_rd_addr;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      point_value_in = point_value_ff;

      if (csr_bus.valid) begin
         used_size_in = csr_bus.used_size;
      end

      // query accumulation off the returning read beat
      if (rd_valid_ff && is_query_ff) begin
         sum_in = add_sum;
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + addr_type'(1);
            if (clr_addr_ff == addr_type'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               state_in    = S_WALK;
               size_in     = eff_size;
               is_query_in = req_bus.op;
               second_in   = !req_bus.op && tree_ok;
               end_in      = idx_type'(req_bus.range_end) + idx_type'(1);
               delta_in    = amt_red;
               sum_in      = '0;
               base_in     = AW'(32'(req_bus.which_tree) * (MAX_POSITIONS + 1));
               // a bad tree gets an empty walk: no update, zero result
               if (!tree_ok) begin
                  idx_in = '0;
               end else if (req_bus.op) begin
                  idx_in = req_pos;
               end else begin
                  idx_in = req_start;
               end
            end
         end
         S_WALK: begin
            if (idx_ok) begin
               idx_in = is_query_ff ? idx_dn : idx_up;
            end else if (second_ff) begin
               // subtraction walk; the last write of the first walk lands this edge
               idx_in    = end_ff;
               second_in = 1'b0;
               delta_in  = delta_neg;
            end else if (is_query_ff) begin
               state_in = S_PUT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               point_value_in = sum_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         used_size_ff <= pos_type'(131072);
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         used_size_ff <= used_size_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff        <= size_in;
      idx_ff         <= idx_in;
      end_ff         <= end_in;
      is_query_ff    <= is_query_in;
      second_ff      <= second_in;
      delta_ff       <= delta_in;
      sum_ff         <= sum_in;
      base_ff        <= base_in;
      wr_addr_ff     <= wr_addr_in;
      point_value_ff <= point_value_in;
   end

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.point_value = point_value_ff;
   assign csr_bus.ready       = 1'b1;

   // no read beat still in flight once a new request can be taken
   `FRAPQ_ASSERT_NOW(a_idle_drained, clock, reset, req_bus.ready, !rd_valid_ff, "read beat in flight at accept")
   // entry 0 of a tree is never touched by a walk
   `FRAPQ_ASSERT_NOW(a_no_entry_zero, clock, reset, rd_valid_ff, wr_addr_ff != base_ff, "walk touched entry zero")
   // response stays a proper residue
   `FRAPQ_ASSERT_NOW(a_rsp_reduced, clock, reset, rsp_valid_ff, point_value_ff < PRIME, "response not reduced")
   // loading the response register carries the finished sum
   `FRAPQ_ASSERT_NEXT(a_rsp_load, clock, reset, (state_ff == S_PUT) && (!rsp_valid_ff || rsp_bus.ready), rsp_valid_ff && (point_value_ff == $past(sum_ff)), "response load lost the sum")
endmodule
`default_nettype wire
